// ===== hdl/dpr_pkg.sv =====
// Package: shared types, constants and the factorial table for the digit rank core.
`timescale 1ns / 1ps
`default_nettype none
package dpr_pkg;

  localparam int unsigned NUM_VALUES_C = 10;   // decimal digit values
  localparam int unsigned MAX_DIGITS_C = 10;   // default digit positions
  localparam int unsigned DIG_W_C      = 4;    // one decimal digit / count / length
  localparam int unsigned RANK_W_C     = 22;   // rank and factorial width
  localparam int unsigned VALUE_W_C    = 32;
  localparam int unsigned FIFO_DEPTH_C = 2;
  localparam logic [31:0] RECIP10_C    = 32'hCCCC_CCCD;  // 2^35 / 10, rounded up

  typedef struct packed {
    logic                                    neg;
    logic [DIG_W_C-1:0]                      len;
    logic [NUM_VALUES_C-1:0][DIG_W_C-1:0]    dig;
    logic [NUM_VALUES_C-1:0][DIG_W_C-1:0]    cnt;
  } item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SPLIT,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DEN,
    B_MUL,
    B_DIV,
    B_ACC,
    B_DONE
  } back_state_e;

  function automatic logic [RANK_W_C-1:0] fact_f(input logic [DIG_W_C-1:0] n);
    logic [RANK_W_C-1:0] f;
    unique case (n)
      4'd0:    f = 22'd1;
      4'd1:    f = 22'd1;
      4'd2:    f = 22'd2;
      4'd3:    f = 22'd6;
      4'd4:    f = 22'd24;
      4'd5:    f = 22'd120;
      4'd6:    f = 22'd720;
      4'd7:    f = 22'd5040;
      4'd8:    f = 22'd40320;
      4'd9:    f = 22'd362880;
      4'd10:   f = 22'd3628800;
      default: f = 22'd1;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/digit_permutation_rank_core.sv =====
// Top level of the digit permutation rank core.
// This core takes a signed 32-bit value per input beat and returns one beat
// holding the zero-based lexicographic rank of the value's decimal digit
// string among all distinct orderings of its digits (repeated digits count
// once per distinct ordering). A negative value returns rank 0 with the
// negative_input flag set; zero and single-digit values return rank 0. Only
// the lowest MAX_DIGITS decimal digits are ranked. The front end splits the
// value into digits at one digit per cycle and hands the item to a two-entry
// queue, so it can take the next beat while the rank engine works. The rank
// engine works through the digit positions one by one: for each it forms the
// product of digit multiplicity factorials, does the numerator multiply, runs
// the serial restoring divider and accumulates the quotient into the rank.
// Results wait in an output register, so a stalled output does not block the
// engine from finishing its current item.
`timescale 1ns / 1ps
`default_nettype none
module digit_permutation_rank_core #(
  parameter int unsigned MAX_DIGITS = dpr_pkg::MAX_DIGITS_C  // 1 to 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value (signed)
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [21:0] rank, [23:22] zero
  output logic             m_axis_tuser    // [0] negative_input
);
  import dpr_pkg::*;

  item_t               push_item, pop_item;
  logic                push, full, pop, empty;
  logic [RANK_W_C-1:0] rank;

  dpr_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  dpr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (empty)
  );

  dpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rank_o  (rank),
    .out_neg_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, rank};

endmodule
`default_nettype wire

// ===== hdl/dpr_front.sv =====
// Front end: accepts a value, flags negatives and splits it into decimal digits.
`timescale 1ns / 1ps
`default_nettype none
module dpr_front #(
  parameter int unsigned MAX_DIGITS = dpr_pkg::MAX_DIGITS_C
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [dpr_pkg::VALUE_W_C-1:0]   in_value_i,
  output logic                                 push_o,
  output dpr_pkg::item_t                       push_item_o,
  input  wire logic                            full_i
);
  import dpr_pkg::*;

  front_state_e state_q, state_d;
  logic [30:0]  v_q;
  item_t        item_q;
  logic [62:0]  prod;
  logic [27:0]  quot;
  logic [30:0]  rem;
  logic [DIG_W_C-1:0] digit;
  logic         split_done;

  // Divide by ten through a reciprocal multiply; the remainder is the digit.
  assign prod       = 63'(v_q) * 63'(RECIP10_C);
  assign quot       = prod[62:35];
  assign rem        = v_q - (31'({quot, 3'b000}) + 31'({quot, 1'b0}));
  assign digit      = rem[DIG_W_C-1:0];
  assign split_done = (v_q == '0) || (item_q.len == DIG_W_C'(MAX_DIGITS));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_valid_i) state_d = in_value_i[31] ? F_PUSH : F_SPLIT;
      F_SPLIT: if (split_done) state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == F_IDLE);
    push_o      = (state_q == F_PUSH) && !full_i;
    push_item_o = item_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      v_q        <= in_value_i[30:0];
      item_q.neg <= in_value_i[31];
      item_q.len <= '0;
      item_q.cnt <= '0;
      item_q.dig <= '0;
    end else if (state_q == F_SPLIT && !split_done) begin
      item_q.dig[item_q.len] <= digit;
      item_q.cnt[digit]      <= item_q.cnt[digit] + 1'b1;
      item_q.len             <= item_q.len + 1'b1;
      v_q                    <= 31'(quot);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dpr_fifo.sv =====
// Small queue of split items between the front end and the rank engine.
`timescale 1ns / 1ps
`default_nettype none
module dpr_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dpr_pkg::item_t push_item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output dpr_pkg::item_t      pop_item_o,
  output logic                empty_o
);
  import dpr_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH_C);

  item_t            mem_q [FIFO_DEPTH_C];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   count_q;

  assign full_o     = (count_q == (PTR_W+1)'(FIFO_DEPTH_C));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH_C-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH_C-1)) ? '0 : rd_q + 1'b1;
      end
      count_q <= count_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dpr_back.sv =====
// Rank engine: per position a denominator product, one multiply and a serial divide.
`timescale 1ns / 1ps
`default_nettype none
module dpr_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          empty_i,
  input  wire dpr_pkg::item_t                item_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [dpr_pkg::RANK_W_C-1:0]       out_rank_o,
  output logic                               out_neg_o
);
  import dpr_pkg::*;

  localparam int unsigned STEP_W = $clog2(RANK_W_C + 1);

  back_state_e state_q, state_d;
  logic [NUM_VALUES_C-1:0][DIG_W_C-1:0] dig_q, cnt_q;
  logic [DIG_W_C-1:0]  k_q, j_q, cur, less, km1;
  logic                neg_q;
  logic [RANK_W_C-1:0] rank_q, denom_q, quo_q, rem_q;
  logic [STEP_W-1:0]   step_q;
  logic [2*RANK_W_C-1:0] den_prod;
  logic [RANK_W_C+3:0] num_prod;
  logic [RANK_W_C:0]   rem_w;
  logic                fits;
  logic                out_valid_q, out_neg_q, load_out;
  logic [RANK_W_C-1:0] out_rank_q;
  logic                start_short;

  assign km1      = k_q - 1'b1;
  assign cur      = dig_q[km1];
  assign den_prod = (2*RANK_W_C)'(denom_q) * (2*RANK_W_C)'(fact_f(cnt_q[j_q]));
  assign num_prod = (RANK_W_C+4)'(less) * (RANK_W_C+4)'(fact_f(km1));
  assign rem_w    = {rem_q, quo_q[RANK_W_C-1]};
  assign fits     = rem_w >= (RANK_W_C+1)'(denom_q);
  assign start_short = item_i.neg || (item_i.len < 4'd2);

  // Remaining digits smaller than the current one.
  always_comb begin
    less = '0;
    for (int i = 0; i < NUM_VALUES_C; i++) begin
      if (DIG_W_C'(i) < cur) less = less + cnt_q[i];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (!empty_i) state_d = start_short ? B_DONE : B_DEN;
      B_DEN:   if (j_q == DIG_W_C'(NUM_VALUES_C-1)) state_d = B_MUL;
      B_MUL:   state_d = B_DIV;
      B_DIV:   if (step_q == STEP_W'(RANK_W_C-1)) state_d = B_ACC;
      B_ACC:   state_d = (k_q == 4'd2) ? B_DONE : B_DEN;
      B_DONE:  if (!out_valid_q || out_ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == B_IDLE) && !empty_i;
    load_out = (state_q == B_DONE) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;
  assign out_rank_o  = out_rank_q;
  assign out_neg_o   = out_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        dig_q   <= item_i.dig;
        cnt_q   <= item_i.cnt;
        k_q     <= item_i.len;
        neg_q   <= item_i.neg;
        rank_q  <= '0;
        j_q     <= '0;
        denom_q <= RANK_W_C'(1);
      end
      B_DEN: begin
        denom_q <= den_prod[RANK_W_C-1:0];
        j_q     <= j_q + 1'b1;
      end
      B_MUL: begin
        quo_q  <= num_prod[RANK_W_C-1:0];
        rem_q  <= '0;
        step_q <= '0;
      end
      B_DIV: begin
        rem_q  <= fits ? RANK_W_C'(rem_w - (RANK_W_C+1)'(denom_q)) : rem_w[RANK_W_C-1:0];
        quo_q  <= {quo_q[RANK_W_C-2:0], fits};
        step_q <= step_q + 1'b1;
      end
      B_ACC: begin
        rank_q     <= rank_q + quo_q;
        cnt_q[cur] <= cnt_q[cur] - 1'b1;
        k_q        <= km1;
        j_q        <= '0;
        denom_q    <= RANK_W_C'(1);
      end
      B_DONE: begin
        if (load_out) begin
          out_rank_q <= neg_q ? '0 : rank_q;
          out_neg_q  <= neg_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
